@@ rtl/bpa_pkg.sv @@
`default_nettype none
package bpa_pkg;

    localparam int ACTION_W = 2;
    localparam int SIZE_W   = 17;
    localparam int OFFS_W   = 20;
    localparam int STATUS_W = 3;
    localparam int STRIDE_W = 13;
    localparam int LINK_BYTES = 8;

    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [ACTION_W-1:0] action_t;

    localparam action_t ACT_ALLOC = 2'd0;
    localparam action_t ACT_FREE  = 2'd1;
    localparam action_t ACT_RESET = 2'd2;

    localparam status_t ST_OK          = 3'd0;
    localparam status_t ST_BAD_SIZE    = 3'd1;
    localparam status_t ST_FULL        = 3'd2;
    localparam status_t ST_UNSUPPORTED = 3'd3;
    localparam status_t ST_OUT_OF_BND  = 3'd4;
    localparam status_t ST_MISALIGNED  = 3'd5;
    localparam status_t ST_DOUBLE_FREE = 3'd6;
    localparam status_t ST_CORRUPTION  = 3'd7;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_ITEM  = 2'd2;
    localparam logic [1:0] REG_ARENA = 2'd3;

endpackage
`default_nettype wire

@@ rtl/block_pool_allocator_core.sv @@
`default_nettype none
// Pool allocator, fixed-block free list or bump arena.
// Command channel: start with action, request_size, block_offset; a
// transaction is taken when start is high and busy is low. Each result is
// shown for one cycle with done high; the receiver cannot stall it.
// Configuration: APB slave, four 32-bit registers at byte 0, 4, 8, 12
// (mode, block count, item bytes, arena bytes). Any write rebuilds
// the pool: a clearing pass walks all MAX_BLOCKS link memory entries one
// entry a cycle, with busy high. The same pass runs after reset.
// Steps from accept to the result:
//   fixed command rejected at accept (size, full, bounds, mode): report
//   arena allocate / reset / reject: arena step, report; fixed allocate: pop, report
//   fixed free: divide (offset / stride, one subtract a cycle), then report
//               when misaligned or nothing is outstanding, else a read and a
//               check per free-list entry stepped past, then push (or reject) and report.
// One subtractor forms the quotient, one multiplier forms the
// stride products, and the registered read of the link memory paces the list walk.
// Busy drops together with done, so the next transaction can be taken at
// the edge that ends the done cycle.
module block_pool_allocator_core
    import bpa_pkg::*;
#(
    parameter int MAX_BLOCKS = 256,
    parameter int LINE_BYTES = 64,
    parameter int BUMP_ALIGN = 16,
    parameter int ARENA_MAX  = 65536
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [SIZE_W-1:0]   request_size,
    input  wire logic [OFFS_W-1:0]   block_offset,
    output logic                     done,
    output logic [STATUS_W-1:0]      status,
    output logic [OFFS_W-1:0]        granted_offset,
    output logic [SIZE_W-1:0]        live_count,
    output logic [SIZE_W-1:0]        used_bytes,
    output logic [SIZE_W-1:0]        remaining_bytes,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int NW = (CW > 9) ? CW : 9;
    localparam int MW = CW + STRIDE_W;
    localparam int PW = (MW > OFFS_W) ? MW : OFFS_W;
    localparam int AW = $clog2(ARENA_MAX + 1);
    localparam int SW = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
    localparam logic [CW-1:0] LINK_END = CW'(MAX_BLOCKS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_ALLOC  = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_WALK   = 4'd4;
    localparam logic [3:0] S_WAIT   = 4'd5;
    localparam logic [3:0] S_VAR    = 4'd6;
    localparam logic [3:0] S_REPORT = 4'd7;

    logic [3:0]           state_reg;
    logic                 mode_reg;
    logic [8:0]           count_reg;
    logic [11:0]          item_reg;
    logic [16:0]          arena_reg;
    logic [CW-1:0]        clr_reg;
    logic [CW-1:0]        head_reg;
    logic [SIZE_W-1:0]    outst_reg;
    logic [SW-1:0]        bump_reg;
    logic [MW-1:0]        limit_reg;
    logic [MW-1:0]        prod_reg;
    logic [ACTION_W-1:0]  act_reg;
    logic [SIZE_W-1:0]    req_reg;
    logic [OFFS_W-1:0]    rem_reg;
    logic [CW-1:0]        idx_reg;
    logic [CW-1:0]        walk_reg;
    logic [CW:0]          steps_reg;
    logic [CW-1:0]        maxfree_reg;
    status_t              status_reg;
    logic [OFFS_W-1:0]    grant_reg;
    logic                 done_reg;
    logic [SIZE_W-1:0]    used_out_reg;
    logic [SIZE_W-1:0]    rem_out_reg;

    logic [CW-1:0]        link_mem [MAX_BLOCKS];
    logic [CW-1:0]        rd_data_reg;

    logic                 cfg_wr;
    logic [CW-1:0]        n_eff;
    logic [SW-1:0]        cap;
    logic [STRIDE_W-1:0]  stride;
    logic [CW-1:0]        mul_a;
    logic [MW-1:0]        mul_res;
    logic [SW-1:0]        bump_aln;
    logic [SW-1:0]        bump_end;
    logic [SW-1:0]        rep_aln;
    logic [CW:0]          clr_inc;
    logic [CW:0]          steps_inc;
    logic [OFFS_W-1:0]    stride_ext;
    logic                 mem_we;
    logic [IW-1:0]        mem_wa;
    logic [CW-1:0]        mem_wd;
    logic [IW-1:0]        mem_ra;
    logic [NW-1:0]        cnt_ext;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign busy   = (state_reg != S_IDLE);

    always_comb
    begin
        cnt_ext = NW'(count_reg);
        if (count_reg == 9'd0)
            n_eff = CW'(1);
        else if (cnt_ext > NW'(MAX_BLOCKS))
            n_eff = LINK_END;
        else
            n_eff = cnt_ext[CW-1:0];
    end

    always_comb
    begin
        if (arena_reg == 17'd0)
            cap = SW'(1);
        else if (SW'(arena_reg) > SW'(ARENA_MAX))
            cap = SW'(ARENA_MAX);
        else
            cap = SW'(arena_reg);
    end

    // Stride: item plus link, rounded up to a whole line.
    assign stride = (STRIDE_W'(item_reg) + STRIDE_W'(LINK_BYTES + LINE_BYTES - 1))
                    & ~STRIDE_W'(LINE_BYTES - 1);
    assign stride_ext = OFFS_W'(stride);

    // Shared multiplier: pool limit while clearing, block offset on allocate.
    assign mul_a   = (state_reg == S_CLEAR) ? n_eff : head_reg;
    assign mul_res = MW'(stride) * MW'(mul_a);

    assign bump_aln = (bump_reg + SW'(BUMP_ALIGN - 1)) & ~SW'(BUMP_ALIGN - 1);
    assign bump_end = bump_aln + SW'(req_reg);
    assign rep_aln  = bump_aln;
    assign clr_inc  = {1'b0, clr_reg} + 1'b1;
    assign steps_inc = steps_reg + 1'b1;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = clr_reg[IW-1:0];
        mem_wd = (clr_inc < {1'b0, n_eff}) ? clr_inc[CW-1:0] : LINK_END;
        mem_ra = head_reg[IW-1:0];
        if (state_reg == S_CLEAR)
            mem_we = 1'b1;
        if (state_reg == S_WALK)
        begin
            mem_ra = walk_reg[IW-1:0];
            if (walk_reg >= n_eff)
            begin
                mem_we = 1'b1;
                mem_wa = idx_reg[IW-1:0];
                mem_wd = head_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[mem_wa] <= mem_wd;
        rd_data_reg <= link_mem[mem_ra];
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MODE:  prdata = {31'd0, mode_reg};
            REG_COUNT: prdata = {23'd0, count_reg};
            REG_ITEM:  prdata = {20'd0, item_reg};
            REG_ARENA: prdata = {15'd0, arena_reg};
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            count_reg <= 9'd256;
            item_reg  <= 12'd56;
            arena_reg <= 17'd65536;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_MODE:  mode_reg  <= pwdata[0];
                REG_COUNT: count_reg <= pwdata[8:0];
                REG_ITEM:  item_reg  <= pwdata[11:0];
                REG_ARENA: arena_reg <= pwdata[16:0];
                default:   mode_reg  <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            limit_reg <= mul_res;
        if (state_reg == S_IDLE)
            prod_reg <= mul_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            head_reg   <= '0;
            outst_reg  <= '0;
            bump_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_wr)
            begin
                // Rebuild the pool from scratch.
                state_reg <= S_CLEAR;
                clr_reg   <= '0;
                head_reg  <= '0;
                outst_reg <= '0;
                bump_reg  <= '0;
            end
            else
            begin
                unique case (state_reg)
                    S_CLEAR:
                    begin
                        clr_reg <= clr_inc[CW-1:0];
                        if (clr_inc == (CW+1)'(MAX_BLOCKS))
                            state_reg <= S_IDLE;
                    end
                    S_IDLE:
                    begin
                        if (start)
                        begin
                            act_reg   <= action;
                            req_reg   <= request_size;
                            rem_reg   <= block_offset;
                            idx_reg   <= '0;
                            grant_reg <= '0;
                            status_reg <= ST_OK;
                            state_reg <= S_REPORT;
                            if (mode_reg)
                                state_reg <= S_VAR;
                            else if (action == ACT_ALLOC)
                            begin
                                if (request_size != SIZE_W'(item_reg))
                                    status_reg <= ST_BAD_SIZE;
                                else if (head_reg >= n_eff)
                                    status_reg <= ST_FULL;
                                else
                                    state_reg <= S_ALLOC;
                            end
                            else if (action == ACT_FREE)
                            begin
                                if (PW'(block_offset) >= PW'(limit_reg))
                                    status_reg <= ST_OUT_OF_BND;
                                else
                                    state_reg <= S_DIV;
                            end
                            else
                                status_reg <= ST_UNSUPPORTED;
                        end
                    end
                    S_ALLOC:
                    begin
                        // Pop the head; the link read was issued at accept.
                        head_reg  <= rd_data_reg;
                        outst_reg <= outst_reg + 1'b1;
                        grant_reg <= prod_reg[OFFS_W-1:0];
                        state_reg <= S_REPORT;
                    end
                    S_DIV:
                    begin
                        // One subtract a cycle: quotient is the block index.
                        if (rem_reg >= stride_ext)
                        begin
                            rem_reg <= rem_reg - stride_ext;
                            idx_reg <= idx_reg + 1'b1;
                        end
                        else if (rem_reg != '0)
                        begin
                            status_reg <= ST_MISALIGNED;
                            state_reg  <= S_REPORT;
                        end
                        else if (outst_reg == '0)
                        begin
                            status_reg <= ST_DOUBLE_FREE;
                            state_reg  <= S_REPORT;
                        end
                        else
                        begin
                            walk_reg  <= head_reg;
                            steps_reg <= '0;
                            maxfree_reg <= (outst_reg <= SIZE_W'(n_eff))
                                ? n_eff - outst_reg[CW-1:0] : '0;
                            state_reg <= S_WALK;
                        end
                    end
                    S_WALK:
                    begin
                        if (walk_reg >= n_eff)
                        begin
                            // End of list reached: push the block.
                            head_reg  <= idx_reg;
                            outst_reg <= outst_reg - 1'b1;
                            state_reg <= S_REPORT;
                        end
                        else if (walk_reg == idx_reg)
                        begin
                            status_reg <= ST_DOUBLE_FREE;
                            state_reg  <= S_REPORT;
                        end
                        else if (steps_inc > {1'b0, maxfree_reg})
                        begin
                            status_reg <= ST_CORRUPTION;
                            state_reg  <= S_REPORT;
                        end
                        else
                        begin
                            steps_reg <= steps_inc;
                            state_reg <= S_WAIT;
                        end
                    end
                    S_WAIT:
                    begin
                        walk_reg  <= rd_data_reg;
                        state_reg <= S_WALK;
                    end
                    S_VAR:
                    begin
                        state_reg <= S_REPORT;
                        if (act_reg == ACT_ALLOC)
                        begin
                            if (req_reg == '0)
                                status_reg <= ST_BAD_SIZE;
                            else if (bump_end > cap)
                                status_reg <= ST_FULL;
                            else
                            begin
                                grant_reg <= OFFS_W'(bump_aln);
                                bump_reg  <= bump_end;
                                if (outst_reg != '1)
                                    outst_reg <= outst_reg + 1'b1;
                            end
                        end
                        else if (act_reg == ACT_RESET)
                        begin
                            bump_reg  <= '0;
                            outst_reg <= '0;
                        end
                        else
                            status_reg <= ST_UNSUPPORTED;
                    end
                    S_REPORT:
                    begin
                        done_reg <= 1'b1;
                        if (mode_reg)
                        begin
                            used_out_reg <= bump_reg[SIZE_W-1:0];
                            rem_out_reg  <= (rep_aln >= cap) ? '0
                                            : SIZE_W'(cap - rep_aln);
                        end
                        else
                        begin
                            used_out_reg <= '0;
                            rem_out_reg  <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                    default:
                        state_reg <= S_CLEAR;
                endcase
            end
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign granted_offset  = grant_reg;
    assign live_count      = outst_reg;
    assign used_bytes      = used_out_reg;
    assign remaining_bytes = rem_out_reg;

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !cfg_wr) |=> busy)
        else $error("busy not raised after accepted transaction");

    a_done_from_report: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_REPORT))
        else $error("done outside report step");

    a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= LINK_END)
        else $error("free head beyond list end");

    a_bump_in_arena: assert property (@(posedge clk) disable iff (!rst_n)
        bump_reg <= cap)
        else $error("bump position beyond arena");

endmodule
`default_nettype wire
